// ----- design/spfe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the strip pulse feature extractor.
// Used by the channel interfaces, controller, datapath and top level.
package spfe_pkg;

  localparam int SAMPLE_DEPTH_DEF = 32;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;

  localparam int STRIP_W  = 10;
  localparam int LAYER_W  = 3;
  localparam int SAMPLE_W = 12;
  localparam int TIME_W   = 18;
  localparam int X_W      = 25;
  localparam int Z_W      = 20;

  localparam logic [7:0]         PERIOD_RESET    = 8'd25;
  localparam logic [16:0]        Z_ION_UM        = 17'd2000;
  localparam logic [STRIP_W-1:0] GAP_STRIP_LIMIT = 10'd256;
  localparam logic [TIME_W-1:0]  TIME_MAX        = 18'h3FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_PERIOD = 3'd0,
    CFG_STRIP_PITCH   = 3'd1,
    CFG_DRIFT_VEL     = 3'd2,
    CFG_PLANE_Z       = 3'd3,
    CFG_GAP_LOW       = 3'd4,
    CFG_GAP_HIGH      = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_POST,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic sample_we;
    logic scan_start;
    logic rd_en;
    logic acc_en;
    logic mul_en;
    logic div_load;
    logic div_step;
    logic post_en;
    logic fin_en;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- design/spfe_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples in and strip results out.
// Field widths come from spfe_pkg.
interface spfe_in_if;
  logic                          valid;
  logic                          ready;
  logic [spfe_pkg::STRIP_W-1:0]  strip_index;
  logic [spfe_pkg::LAYER_W-1:0]  layer_index;
  logic [spfe_pkg::SAMPLE_W-1:0] sample_value;
  logic                          last_sample;

  modport source (output valid, strip_index, layer_index, sample_value, last_sample,
                  input ready);
  modport sink   (input valid, strip_index, layer_index, sample_value, last_sample,
                  output ready);
endinterface

interface spfe_out_if;
  logic                               valid;
  logic                               ready;
  logic [spfe_pkg::STRIP_W-1:0]       hit_strip;
  logic [spfe_pkg::LAYER_W-1:0]       hit_layer;
  logic [spfe_pkg::TIME_W-1:0]        strip_time;
  logic [spfe_pkg::SAMPLE_W-1:0]      peak_charge;
  logic signed [spfe_pkg::X_W-1:0]    strip_x;
  logic signed [spfe_pkg::Z_W-1:0]    strip_z;
  logic                               overflow;

  modport source (output valid, hit_strip, hit_layer, strip_time, peak_charge, strip_x,
                         strip_z, overflow,
                  input ready);
  modport sink   (input valid, hit_strip, hit_layer, strip_time, peak_charge, strip_x,
                        strip_z, overflow,
                  output ready);
endinterface

// ----- design/spfe_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences sample intake, buffer scan, divide and result load.
// Depends on spfe_pkg for state, command and status types.
module spfe_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  spfe_pkg::sts_t   sts,
  output spfe_pkg::cmd_t   cmd,
  output spfe_pkg::state_t state
);

  spfe_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spfe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      spfe_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.sample_we  = in_valid;
        cmd.scan_start = in_valid && in_last;
        if (in_valid && in_last) begin
          state_nxt = spfe_pkg::ST_READ;
        end
      end
      spfe_pkg::ST_READ: begin
        if (sts.scan_done) begin
          state_nxt = spfe_pkg::ST_MUL;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = spfe_pkg::ST_ACC;
        end
      end
      spfe_pkg::ST_ACC: begin
        cmd.acc_en = 1'b1;
        state_nxt  = spfe_pkg::ST_READ;
      end
      spfe_pkg::ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = spfe_pkg::ST_DLOAD;
      end
      spfe_pkg::ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = spfe_pkg::ST_DIV;
      end
      spfe_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = spfe_pkg::ST_POST;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      spfe_pkg::ST_POST: begin
        cmd.post_en = 1'b1;
        state_nxt   = spfe_pkg::ST_FIN;
      end
      spfe_pkg::ST_FIN: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.fin_en = 1'b1;
          state_nxt  = spfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = spfe_pkg::ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

// ----- design/spfe_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: sample buffer, accumulators, centroid sums, serial divider,
// position/depth arithmetic, configuration registers and result register.
module spfe_datapath #(
  parameter int SAMPLE_DEPTH = spfe_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spfe_pkg::cmd_t                      cmd,
  output spfe_pkg::sts_t                      sts,
  input  logic [spfe_pkg::STRIP_W-1:0]        strip_index,
  input  logic [spfe_pkg::LAYER_W-1:0]        layer_index,
  input  logic [spfe_pkg::SAMPLE_W-1:0]       sample_value,
  input  logic                                cfg_we,
  input  logic [spfe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spfe_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spfe_pkg::STRIP_W-1:0]        hit_strip,
  output logic [spfe_pkg::LAYER_W-1:0]        hit_layer,
  output logic [spfe_pkg::TIME_W-1:0]         strip_time,
  output logic [spfe_pkg::SAMPLE_W-1:0]       peak_charge,
  output logic signed [spfe_pkg::X_W-1:0]     strip_x,
  output logic signed [spfe_pkg::Z_W-1:0]     strip_z,
  output logic                                overflow
);

  localparam int QW  = spfe_pkg::SAMPLE_W;
  localparam int AW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
  localparam int CW  = $clog2(SAMPLE_DEPTH + 1);
  localparam int TW  = QW + CW;        // charge total and used weight
  localparam int SW  = QW + 2 * CW;    // sum of q*(2i+1)
  localparam int NW  = SW + 11;        // 8 * period * sum
  localparam int DCW = $clog2(NW + 1);
  localparam int PW  = QW + CW + 3;    // 5*q*N
  localparam int TMW = spfe_pkg::TIME_W;

  // configuration
  logic [7:0]  period_r;
  logic [11:0] pitch_r;
  logic [15:0] dvel_r;
  logic [15:0] plane_z_r;
  logic [63:0] gap_lo_r;
  logic [63:0] gap_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= spfe_pkg::PERIOD_RESET;
      pitch_r   <= '0;
      dvel_r    <= '0;
      plane_z_r <= '0;
      gap_lo_r  <= '0;
      gap_hi_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spfe_pkg::CFG_SAMPLE_PERIOD: period_r  <= cfg_data[7:0];
        spfe_pkg::CFG_STRIP_PITCH:   pitch_r   <= cfg_data[11:0];
        spfe_pkg::CFG_DRIFT_VEL:     dvel_r    <= cfg_data[15:0];
        spfe_pkg::CFG_PLANE_Z:       plane_z_r <= cfg_data[15:0];
        spfe_pkg::CFG_GAP_LOW:       gap_lo_r  <= cfg_data;
        spfe_pkg::CFG_GAP_HIGH:      gap_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample buffer
  logic [QW-1:0] store_mem [SAMPLE_DEPTH];
  logic [QW-1:0] rd_q_r;

  logic [CW-1:0] count_r;
  logic [TW-1:0] total_r;
  logic [QW-1:0] peak_r;
  logic          drop_r;
  logic          room;

  assign room = count_r < CW'(SAMPLE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.sample_we && room) begin
      store_mem[count_r[AW-1:0]] <= sample_value;
    end
  end

  logic [CW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q_r <= store_mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
      peak_r  <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.fin_en) begin
      count_r <= '0;
      total_r <= '0;
      peak_r  <= '0;
      drop_r  <= 1'b0;
    end else if (cmd.sample_we) begin
      if (room) begin
        count_r <= count_r + CW'(1);
        total_r <= total_r + TW'(sample_value);
        if (sample_value > peak_r) begin
          peak_r <= sample_value;
        end
      end else begin
        drop_r <= 1'b1;
      end
    end
  end

  // hit identity of the final item
  logic [spfe_pkg::STRIP_W-1:0] strip_r;
  logic [spfe_pkg::LAYER_W-1:0] layer_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      strip_r <= strip_index;
      layer_r <= layer_index;
    end
  end

  // scan: threshold test and weighted sums
  logic [QW+CW-1:0] qn;
  logic [PW-1:0]    q5n;
  logic             keep;
  logic [AW:0]      odd;
  logic [QW+AW:0]   qodd;
  logic [SW-1:0]    wsum_t_r;
  logic [TW-1:0]    wsum_r;

  assign qn   = (QW + CW)'(rd_q_r) * (QW + CW)'(count_r);
  assign q5n  = {1'b0, qn, 2'b00} + PW'(qn);
  assign keep = q5n >= PW'(total_r);
  assign odd  = {idx_r[AW-1:0], 1'b1};
  assign qodd = (QW + AW + 1)'(rd_q_r) * (QW + AW + 1)'(odd);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx_r    <= '0;
      wsum_t_r <= '0;
      wsum_r   <= '0;
    end else if (cmd.acc_en) begin
      idx_r <= idx_r + CW'(1);
      if (keep) begin
        wsum_t_r <= wsum_t_r + SW'(qodd);
        wsum_r   <= wsum_r + TW'(rd_q_r);
      end
    end
  end

  assign sts.scan_done = idx_r == count_r;

  // numerator: 8 * period * sum
  logic [NW-1:0] num_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      num_r <= {(SW + 8)'(wsum_t_r) * (SW + 8)'(period_r), 3'b000};
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [NW-1:0]  quo_r;
  logic [TW-1:0]  rem_r;
  logic [DCW-1:0] dcnt_r;
  logic [TW:0]    rem_sh;
  logic [TW:0]    rem_sub;
  logic           ge;

  assign rem_sh  = {rem_r, quo_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, wsum_r};
  assign ge      = rem_sh >= {1'b0, wsum_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_load) begin
      dcnt_r <= DCW'(NW);
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r <= num_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
    end
  end

  assign sts.div_done = dcnt_r == '0;

  // time saturation and drift distance
  logic [TMW-1:0] t_sat;
  logic [TMW-1:0] t_r;
  logic [21:0]    dist_r;
  logic [33:0]    tdv;

  always_comb begin
    if (wsum_r == '0) begin
      t_sat = '0;
    end else if (|quo_r[NW-1:TMW]) begin
      t_sat = spfe_pkg::TIME_MAX;
    end else begin
      t_sat = quo_r[TMW-1:0];
    end
  end

  assign tdv = 34'(t_sat) * 34'(dvel_r);

  always_ff @(posedge clk) begin
    if (cmd.post_en) begin
      t_r    <= t_sat;
      dist_r <= tdv[33:12];
    end
  end

  // x position and z depth
  logic [63:0]        gap_reg;
  logic [15:0]        gap;
  logic signed [12:0] sm1;
  logic signed [25:0] x_full;
  logic [16:0]        zbase;
  logic signed [23:0] z_full;
  logic signed [spfe_pkg::Z_W-1:0] z_sat;

  assign gap_reg = layer_r[2] ? gap_hi_r : gap_lo_r;
  assign gap     = gap_reg[{layer_r[1:0], 4'b0000} +: 16];
  assign sm1     = $signed({2'b00, strip_r, 1'b0}) - 13'sd1;

  always_comb begin
    x_full = 26'(sm1) * $signed({14'b0, pitch_r});
    if (strip_r > spfe_pkg::GAP_STRIP_LIMIT) begin
      x_full = x_full + $signed({9'b0, gap, 1'b0});
    end
  end

  assign zbase = 17'(plane_z_r) + spfe_pkg::Z_ION_UM;

  always_comb begin
    if (!layer_r[2]) begin
      z_full = $signed({7'b0, zbase}) - $signed({2'b00, dist_r});
    end else begin
      z_full = $signed({2'b00, dist_r}) - $signed({7'b0, zbase});
    end
    if (z_full < -24'sd524288) begin
      z_sat = {1'b1, {(spfe_pkg::Z_W - 1){1'b0}}};
    end else if (z_full > 24'sd524287) begin
      z_sat = {1'b0, {(spfe_pkg::Z_W - 1){1'b1}}};
    end else begin
      z_sat = z_full[spfe_pkg::Z_W-1:0];
    end
  end

  // result register
  logic out_valid_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      hit_strip   <= strip_r;
      hit_layer   <= layer_r;
      strip_time  <= t_r;
      peak_charge <= peak_r;
      strip_x     <= x_full[spfe_pkg::X_W-1:0];
      strip_z     <= z_sat;
      overflow    <= drop_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/strip_pulse_feature_extractor.sv -----
`timescale 1ns / 1ps
// Top level of the strip pulse feature extractor: controller plus datapath.
// Depends on spfe_pkg, spfe_if, spfe_ctrl and spfe_datapath.
//
//   channel | direction | handshake   | transaction
//   in_if   | sink      | valid/ready | one ADC sample, last_sample ends a strip
//   out_if  | source    | valid/ready | one hit result per strip
//   cfg_*   | write     | cfg_we      | one register write, no read-back
//
// Samples are taken one per cycle while idle. After the last sample the buffer
// is scanned with a read and an accumulate state per held sample, the
// numerator is formed and loaded, the divider yields NW quotient bits with
// NW = 12 + 2*clog2(SAMPLE_DEPTH+1) + 11 (35 at depth 32, one bit per cycle),
// then the post and final states load the result and return to idle.
// Reset is synchronous; the sample buffer is not cleared, only its count.
// A pending result in the output register does not block new samples; the
// next result waits in the final state until that register is free.
module strip_pulse_feature_extractor #(
  parameter int SAMPLE_DEPTH = spfe_pkg::SAMPLE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  spfe_in_if.sink                         in_if,
  spfe_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [spfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spfe_pkg::CFG_DATA_W-1:0] cfg_data
);

  spfe_pkg::cmd_t   cmd;
  spfe_pkg::sts_t   sts;
  spfe_pkg::state_t state;

  spfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_last  (in_if.last_sample),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd),
    .state    (state)
  );

  spfe_datapath #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .strip_index  (in_if.strip_index),
    .layer_index  (in_if.layer_index),
    .sample_value (in_if.sample_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .hit_strip    (out_if.hit_strip),
    .hit_layer    (out_if.hit_layer),
    .strip_time   (out_if.strip_time),
    .peak_charge  (out_if.peak_charge),
    .strip_x      (out_if.strip_x),
    .strip_z      (out_if.strip_z),
    .overflow     (out_if.overflow)
  );

  a_last_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready && in_if.last_sample |=> !in_if.ready)
    else $error("input taken right after a final sample");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(cmd.fin_en))
    else $error("result raised without a load");

  a_fin_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_en |-> sts.out_free && state == spfe_pkg::ST_FIN)
    else $error("result loaded over a pending one");

endmodule
